>>> hw/rtl/hrkm_pkg.sv
package hrkm_pkg;

  // Defaults for the top-level parameters
  localparam int ROWS_DEF        = 12;
  localparam int COLUMNS_DEF     = 12;
  localparam int REPORT_KEYS_DEF = 6;

  // Fixed dimensions of the interface
  localparam int KEYS_MAX  = 6;   // keycode slots in a boot report
  localparam int OUT_W     = 12;  // column_drive width
  localparam int MAX_DIM   = 16;  // a nibble addresses up to 16 rows/columns
  localparam int MAP_DEPTH = 512; // plain map followed by shifted map
  localparam int MAP_AW    = 9;

  localparam logic [7:0] NO_MAP = 8'hFF;

  // Item kinds
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_SCAN   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_KEY_RD,
    ST_KEY_PR,
    ST_SCAN
  } st_t;

  // Table write towards the map store
  typedef struct packed {
    logic        key_en;
    logic        mod_en;
    logic [9:0]  addr;
    logic [7:0]  data;
  } tbl_wr_t;

  // Matrix update command
  typedef struct packed {
    logic        release_all;
    logic        press;
    logic [7:0]  entry;
  } press_t;

endpackage

>>> hw/rtl/hrkm_map_store.sv
module hrkm_map_store
  import hrkm_pkg::*;
(
  input  logic               clk,
  input  tbl_wr_t            tbl_wr,
  input  logic [MAP_AW-1:0]  key_rd_addr,
  input  logic [1:0]         mod_idx,
  output logic [7:0]         key_data,
  output logic [7:0]         mod_entry
);

  logic [7:0] map_mem [MAP_DEPTH];
  logic [7:0] mod_map_r [4];
  logic [7:0] key_data_r;

  // Plain and shifted key maps: one write port, registered read
  always_ff @(posedge clk) begin
    if (tbl_wr.key_en) begin
      map_mem[tbl_wr.addr[MAP_AW-1:0]] <= tbl_wr.data;
    end
    key_data_r <= map_mem[key_rd_addr];
  end

  // Modifier entries: ctrl, shift, alt, gui
  always_ff @(posedge clk) begin
    if (tbl_wr.mod_en) begin
      mod_map_r[tbl_wr.addr[1:0]] <= tbl_wr.data;
    end
  end

  assign key_data  = key_data_r;
  assign mod_entry = mod_map_r[mod_idx];

endmodule

>>> hw/rtl/hrkm_matrix.sv
module hrkm_matrix
  import hrkm_pkg::*;
#(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  press_t            press,
  input  logic [OUT_W-1:0]  scan_lines,
  output logic [OUT_W-1:0]  scan_drive
);

  localparam int SCAN_ROWS = (ROWS < OUT_W) ? ROWS : OUT_W;

  // One bit per key, 0 = pressed
  logic [COLUMNS-1:0] rows_r   [ROWS];
  logic [COLUMNS-1:0] rows_nxt [ROWS];

  logic [3:0]         p_row;
  logic [3:0]         p_col;
  logic               p_hit;
  logic [MAX_DIM-1:0] drive_w;

  assign p_row = press.entry[7:4];
  assign p_col = press.entry[3:0];
  // Unmapped entries and positions off the matrix press nothing
  assign p_hit = press.press && (press.entry != NO_MAP) &&
                 ({1'b0, p_row} < 5'(ROWS)) && ({1'b0, p_col} < 5'(COLUMNS));

  // Release / press update
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      rows_nxt[r] = rows_r[r];
      if (press.release_all) begin
        rows_nxt[r] = '1;
      end else if (p_hit && (p_row == 4'(r))) begin
        for (int c = 0; c < COLUMNS; c++) begin
          if (p_col == 4'(c)) begin
            rows_nxt[r][c] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < ROWS; r++) begin
      if (!rst_n) begin
        rows_r[r] <= '1;
      end else begin
        rows_r[r] <= rows_nxt[r];
      end
    end
  end

  // Lowest active-low line wins; none active gives zero
  always_comb begin
    drive_w = '0;
    for (int r = SCAN_ROWS - 1; r >= 0; r--) begin
      if (!scan_lines[r]) begin
        drive_w = '0;
        drive_w[COLUMNS-1:0] = ~rows_r[r];
      end
    end
  end

  assign scan_drive = drive_w[OUT_W-1:0];

endmodule

>>> hw/rtl/hrkm_seq.sv
module hrkm_seq
  import hrkm_pkg::*;
#(
  parameter int REPORT_KEYS = REPORT_KEYS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [9:0]         in_table_address,
  input  logic [7:0]         in_table_value,
  input  logic [7:0]         in_modifiers,
  input  logic [7:0]         key_codes [REPORT_KEYS],
  input  logic [OUT_W-1:0]   in_row_lines,
  input  logic               shift_en,
  input  logic               out_free,
  input  logic [7:0]         key_data,
  input  logic [7:0]         mod_entry,
  output tbl_wr_t            tbl_wr,
  output logic [MAP_AW-1:0]  key_rd_addr,
  output logic [1:0]         mod_idx,
  output press_t             press,
  output logic               scan_load,
  output logic [OUT_W-1:0]   scan_lines
);

  localparam int KW = (REPORT_KEYS > 1) ? $clog2(REPORT_KEYS) : 1;

  st_t               state_r, state_nxt;
  logic [1:0]        mod_cnt_r, mod_cnt_nxt;
  logic [KW-1:0]     key_cnt_r, key_cnt_nxt;
  logic [7:0]        mods_r;
  logic [7:0]        codes_r [REPORT_KEYS];
  logic              use_shift_r;
  logic [OUT_W-1:0]  lines_r;

  logic              accept;
  logic              rpt_acc;
  logic [7:0]        cur_code;

  assign in_stall = (state_r != ST_IDLE) || !rst_n;
  assign accept   = in_valid && !in_stall;
  assign rpt_acc  = accept && (in_kind == KIND_REPORT);
  assign cur_code = codes_r[key_cnt_r];

  // Table writes land at the accept edge
  always_comb begin
    tbl_wr.addr   = in_table_address;
    tbl_wr.data   = in_table_value;
    tbl_wr.key_en = accept && (in_kind == KIND_WRITE) && !in_table_address[9];
    tbl_wr.mod_en = accept && (in_kind == KIND_WRITE) && in_table_address[9] &&
                    (in_table_address[8:2] == '0);
  end

  assign key_rd_addr = {use_shift_r, cur_code};
  assign mod_idx     = mod_cnt_r;
  assign scan_lines  = lines_r;

  // Item capture
  always_ff @(posedge clk) begin
    if (rpt_acc) begin
      mods_r      <= in_modifiers;
      use_shift_r <= shift_en && ((in_modifiers[1] | in_modifiers[5]) == 1'b1);
      for (int k = 0; k < REPORT_KEYS; k++) begin
        codes_r[k] <= key_codes[k];
      end
    end
    if (accept && (in_kind == KIND_SCAN)) begin
      lines_r <= in_row_lines;
    end
  end

  // Sequencer: modifiers, then one lookup and one press per keycode; a scan waits for out_free
  always_comb begin
    state_nxt         = state_r;
    mod_cnt_nxt       = mod_cnt_r;
    key_cnt_nxt       = key_cnt_r;
    press.release_all = rpt_acc;
    press.press       = 1'b0;
    press.entry       = mod_entry;
    scan_load         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        mod_cnt_nxt = '0;
        key_cnt_nxt = '0;
        if (rpt_acc) begin
          state_nxt = ST_MOD;
        end else if (accept && (in_kind == KIND_SCAN)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_MOD: begin
        press.press = mods_r[{1'b0, mod_cnt_r}] | mods_r[{1'b1, mod_cnt_r}];
        mod_cnt_nxt = mod_cnt_r + 2'd1;
        if (mod_cnt_r == 2'd3) begin
          state_nxt = ST_KEY_RD;
        end
      end
      ST_KEY_RD: begin
        state_nxt = ST_KEY_PR;
      end
      ST_KEY_PR: begin
        press.press = (cur_code != 8'd0);
        press.entry = key_data;
        if (key_cnt_r == KW'(REPORT_KEYS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          key_cnt_nxt = key_cnt_r + KW'(1);
          state_nxt   = ST_KEY_RD;
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          scan_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mod_cnt_r <= '0;
      key_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      mod_cnt_r <= mod_cnt_nxt;
      key_cnt_r <= key_cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/hid_report_to_key_matrix.sv
// Key matrix emulator fed by boot-keyboard reports.
// Input channel (in_valid / in_stall): one item per handshake, chosen by in_kind:
//   table write  - stores in_table_value at in_table_address (plain map,
//                  shifted map or one of four modifier entries).
//   report       - releases every key, then presses the mapped positions of
//                  held modifiers and nonzero keycodes. A sequencer walks the
//                  four modifier entries one per cycle and then does a map
//                  read plus a press per keycode, as the single map read
//                  port is registered.
//   row scan     - returns the pressed columns of the lowest low row line
//                  (zero if none) on out_column_drive; the item waits in its
//                  scan state until the output register is free.
// Other kinds are dropped. in_stall is high while an item is being worked on.
// Config channel (cfg_valid / cfg_ready, always ready): bit 0 enables the
// shifted map while either shift is held. Write it only when idle.
// Output channel (out_valid / out_stall): one registered item per scan; while
// the receiver stalls the item holds and table writes and reports are still
// taken, but a scan item waits in its own state and blocks the input.
// Reset (rst_n low, synchronous) releases all keys, clears the enable and
// empties the output; the maps hold nothing valid until written.
module hid_report_to_key_matrix
  import hrkm_pkg::*;
#(
  parameter int ROWS        = ROWS_DEF,
  parameter int COLUMNS     = COLUMNS_DEF,
  parameter int REPORT_KEYS = REPORT_KEYS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_kind,
  input  logic [9:0]        in_table_address,
  input  logic [7:0]        in_table_value,
  input  logic [7:0]        in_modifiers,
  input  logic [7:0]        in_key_code_0,
  input  logic [7:0]        in_key_code_1,
  input  logic [7:0]        in_key_code_2,
  input  logic [7:0]        in_key_code_3,
  input  logic [7:0]        in_key_code_4,
  input  logic [7:0]        in_key_code_5,
  input  logic [11:0]       in_row_lines,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [11:0]       out_column_drive,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  logic [7:0]        codes_all [KEYS_MAX];
  logic [7:0]        codes [REPORT_KEYS];
  logic              shift_en_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_drive_r;
  logic              out_free;

  tbl_wr_t           tbl_wr;
  press_t            press;
  logic [MAP_AW-1:0] key_rd_addr;
  logic [1:0]        mod_idx;
  logic [7:0]        key_data;
  logic [7:0]        mod_entry;
  logic              scan_load;
  logic [OUT_W-1:0]  scan_lines;
  logic [OUT_W-1:0]  scan_drive;

  assign codes_all[0] = in_key_code_0;
  assign codes_all[1] = in_key_code_1;
  assign codes_all[2] = in_key_code_2;
  assign codes_all[3] = in_key_code_3;
  assign codes_all[4] = in_key_code_4;
  assign codes_all[5] = in_key_code_5;

  // Only the first REPORT_KEYS slots are used
  for (genvar k = 0; k < REPORT_KEYS; k++) begin : g_codes
    assign codes[k] = codes_all[k];
  end

  // Shifted-map enable register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_en_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      shift_en_r <= cfg_data;
    end
  end

  // Output register
  assign out_free = !out_valid_r || !out_stall;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (scan_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_load) begin
      out_drive_r <= scan_drive;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_column_drive = out_drive_r;

  hrkm_seq #(
    .REPORT_KEYS (REPORT_KEYS)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_table_address (in_table_address),
    .in_table_value   (in_table_value),
    .in_modifiers     (in_modifiers),
    .key_codes        (codes),
    .in_row_lines     (in_row_lines),
    .shift_en         (shift_en_r),
    .out_free         (out_free),
    .key_data         (key_data),
    .mod_entry        (mod_entry),
    .tbl_wr           (tbl_wr),
    .key_rd_addr      (key_rd_addr),
    .mod_idx          (mod_idx),
    .press            (press),
    .scan_load        (scan_load),
    .scan_lines       (scan_lines)
  );

  hrkm_map_store u_store (
    .clk         (clk),
    .tbl_wr      (tbl_wr),
    .key_rd_addr (key_rd_addr),
    .mod_idx     (mod_idx),
    .key_data    (key_data),
    .mod_entry   (mod_entry)
  );

  hrkm_matrix #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_matrix (
    .clk        (clk),
    .rst_n      (rst_n),
    .press      (press),
    .scan_lines (scan_lines),
    .scan_drive (scan_drive)
  );

endmodule

>>> hw/rtl/hrkm_checker.sv
module hrkm_checker
  import hrkm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [11:0] out_column_drive
);

  // Output is empty after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item present after reset");

  // A held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_column_drive))
    else $error("stalled result item changed");

  // A report keeps the input busy through the modifier pass
  a_rpt_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind == KIND_REPORT) |=> in_stall ##4 in_stall)
    else $error("report item finished too early");

  // An accepted scan makes the input stall
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind == KIND_SCAN) |=> in_stall)
    else $error("input taken while scan pending");

  // A new result only follows a busy cycle
  a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result item without a scan");

endmodule

bind hid_report_to_key_matrix hrkm_checker u_chk (.*);

>>> tb/tb_hid_report_to_key_matrix.sv
`timescale 1ns / 1ps

module tb_hid_report_to_key_matrix;
  import hrkm_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int SHIFT_BASE       = 256;
  localparam int MOD_BASE         = 512;
  localparam int MOD_END          = 516;
  localparam int SETTLE_CYCLES    = 30;   // outlasts a report still in flight
  localparam int RANDOM_PER_PHASE = 480;

  // One input item as the sender sees it
  typedef struct {
    logic [1:0]  kind;
    logic [9:0]  addr;
    logic [7:0]  value;
    logic [7:0]  mods;
    logic [7:0]  keys [KEYS_MAX];
    logic [11:0] lines;
  } key_item_t;

  // Tracks the emulated matrix and the maps, and holds the column drives owed
  class key_matrix_board;
    logic [11:0] key_rows [ROWS_DEF];   // 0 = key pressed
    logic [7:0]  plain_keys [256];
    logic [7:0]  shifted_keys [256];
    logic [7:0]  modifier_keys [4];
    bit          shift_map_on;
    logic [11:0] owed_drives [$];
    int unsigned errors;

    function new();
      release_keys();
      shift_map_on = 1'b0;
      errors = 0;
    endfunction

    function void release_keys();
      for (int r = 0; r < ROWS_DEF; r++) key_rows[r] = '1;
    endfunction

    function void press_key(logic [7:0] entry);
      if (entry != NO_MAP && entry[7:4] < ROWS_DEF && entry[3:0] < COLUMNS_DEF)
        key_rows[entry[7:4]][entry[3:0]] = 1'b0;
    endfunction

    // Applies one accepted item; a scan queues the drive it should return
    function void note_item(key_item_t it);
      bit          use_shifted;
      logic [11:0] drive;
      case (it.kind)
        KIND_WRITE: begin
          if (it.addr < SHIFT_BASE) plain_keys[it.addr] = it.value;
          else if (it.addr < MOD_BASE) shifted_keys[it.addr - SHIFT_BASE] = it.value;
          else if (it.addr < MOD_END) modifier_keys[it.addr - MOD_BASE] = it.value;
        end
        KIND_REPORT: begin
          release_keys();
          for (int m = 0; m < 4; m++)
            if (it.mods[m] || it.mods[m + 4]) press_key(modifier_keys[m]);
          use_shifted = (it.mods[1] || it.mods[5]) && shift_map_on;
          for (int k = 0; k < REPORT_KEYS_DEF; k++)
            if (it.keys[k] != 8'd0)
              press_key(use_shifted ? shifted_keys[it.keys[k]] : plain_keys[it.keys[k]]);
        end
        KIND_SCAN: begin
          drive = '0;
          for (int r = 0; r < ROWS_DEF; r++) begin
            if (!it.lines[r]) begin
              drive = ~key_rows[r];
              break;
            end
          end
          owed_drives.push_back(drive);
        end
        default: ;
      endcase
    endfunction

    function void check_drive(logic [11:0] got);
      logic [11:0] want;
      if (owed_drives.size() == 0) begin
        $display("%0t: unexpected column drive item, actual %03h", $time, got);
        errors++;
      end else begin
        want = owed_drives.pop_front();
        if (got !== want) begin
          $display("%0t: column_drive mismatch, expected %03h actual %03h",
                   $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [9:0]  in_table_address;
  logic [7:0]  in_table_value;
  logic [7:0]  in_modifiers;
  logic [7:0]  in_key_code_0, in_key_code_1, in_key_code_2;
  logic [7:0]  in_key_code_3, in_key_code_4, in_key_code_5;
  logic [11:0] in_row_lines;
  logic        out_valid;
  logic        out_stall;
  logic [11:0] out_column_drive;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  key_matrix_board board = new();
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int hold_request = 0;

  hid_report_to_key_matrix DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_table_address (in_table_address),
    .in_table_value   (in_table_value),
    .in_modifiers     (in_modifiers),
    .in_key_code_0    (in_key_code_0),
    .in_key_code_1    (in_key_code_1),
    .in_key_code_2    (in_key_code_2),
    .in_key_code_3    (in_key_code_3),
    .in_key_code_4    (in_key_code_4),
    .in_key_code_5    (in_key_code_5),
    .in_row_lines     (in_row_lines),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_column_drive (out_column_drive),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Map entry: mostly inside the matrix, some unmapped, some anywhere
  function automatic logic [7:0] rand_entry();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return NO_MAP;
    if (sel < 25) return 8'($urandom_range(255));
    return {4'($urandom_range(ROWS_DEF - 1)), 4'($urandom_range(COLUMNS_DEF - 1))};
  endfunction

  // Row lines with a chosen lowest low line, or none low at all
  function automatic logic [11:0] rand_lines();
    int          r;
    logic [11:0] sel_bit;
    if ($urandom_range(99) < 10) return 12'hFFF;
    r = $urandom_range(11);
    sel_bit = 12'h1 << r;
    return (12'($urandom()) | (sel_bit - 12'h1)) & ~sel_bit;
  endfunction

  function automatic key_item_t rand_item();
    key_item_t it;
    int        sel;
    sel      = $urandom_range(99);
    it.kind  = (sel < 35) ? KIND_REPORT : (sel < 80) ? KIND_SCAN :
               (sel < 95) ? KIND_WRITE : KIND_UNUSED;
    it.addr  = ($urandom_range(99) < 85) ? 10'($urandom_range(MOD_END - 1))
                                         : 10'($urandom_range(1023));
    it.value = rand_entry();
    it.mods  = ($urandom_range(99) < 30) ? 8'd0 : 8'($urandom_range(255));
    foreach (it.keys[k])
      it.keys[k] = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    it.lines = rand_lines();
    return it;
  endfunction

  function automatic key_item_t mk_write(int addr, logic [7:0] value);
    key_item_t it;
    it = rand_item();
    it.kind  = KIND_WRITE;
    it.addr  = 10'(addr);
    it.value = value;
    return it;
  endfunction

  function automatic key_item_t mk_report(logic [7:0] mods, logic [47:0] codes);
    key_item_t it;
    it = rand_item();
    it.kind = KIND_REPORT;
    it.mods = mods;
    foreach (it.keys[k]) it.keys[k] = codes[8 * k +: 8];
    return it;
  endfunction

  function automatic key_item_t mk_scan(logic [11:0] lines);
    key_item_t it;
    it = rand_item();
    it.kind  = KIND_SCAN;
    it.lines = lines;
    return it;
  endfunction

  // Offers one item, idling at random beforehand, and returns on acceptance
  task automatic send_item(input key_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= it.kind;
    in_table_address <= it.addr;
    in_table_value   <= it.value;
    in_modifiers     <= it.mods;
    in_key_code_0    <= it.keys[0];
    in_key_code_1    <= it.keys[1];
    in_key_code_2    <= it.keys[2];
    in_key_code_3    <= it.keys[3];
    in_key_code_4    <= it.keys[4];
    in_key_code_5    <= it.keys[5];
    in_row_lines     <= it.lines;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(it);
  endtask

  // Waits for every owed drive, then lets a report still in flight finish
  task automatic drain();
    in_valid <= 1'b0;
    while (board.owed_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_shift_map(input bit on);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= on;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.shift_map_on = on;
  endtask

  // Result side: checks each accepted item and stalls at random or on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) board.check_drive(out_column_drive);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_kind          <= KIND_WRITE;
    in_table_address <= '0;
    in_table_value   <= '0;
    in_modifiers     <= '0;
    in_key_code_0    <= '0;
    in_key_code_1    <= '0;
    in_key_code_2    <= '0;
    in_key_code_3    <= '0;
    in_key_code_4    <= '0;
    in_key_code_5    <= '0;
    in_row_lines     <= '1;
    cfg_valid        <= 1'b0;
    cfg_data         <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load every map entry so no report reads an unwritten one
    for (int a = 0; a < MOD_END; a++) send_item(mk_write(a, rand_entry()));

    // Directed: modifier entries at the corners, unmapped and off-matrix
    send_item(mk_write(MOD_BASE + 0, 8'h00));
    send_item(mk_write(MOD_BASE + 1, 8'hBB));
    send_item(mk_write(MOD_BASE + 2, NO_MAP));
    send_item(mk_write(MOD_BASE + 3, 8'hC3));
    // writes past the modifier entries are dropped
    send_item(mk_write(MOD_END, 8'h11));
    send_item(mk_write(1023, 8'h22));
    send_item(mk_write(4, 8'h0C));
    send_item(mk_write(255, 8'hB0));
    send_item(mk_write(SHIFT_BASE + 255, 8'h0B));
    begin
      key_item_t odd;
      odd = rand_item();
      odd.kind = KIND_UNUSED;
      send_item(odd);
    end
    // all modifiers, shift map still off
    send_item(mk_report(8'hFF, {8'd0, 8'd0, 8'd0, 8'd0, 8'd4, 8'd255}));
    send_item(mk_scan(12'h000));
    send_item(mk_scan(12'h7FF));
    send_item(mk_scan(12'hFFF));
    send_item(mk_report(8'h00, 48'd0));
    send_item(mk_scan(12'h7FF));

    // shifted map in use with either shift key
    set_shift_map(1'b1);
    send_item(mk_report(8'h20, {8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}));
    send_item(mk_scan(12'hFFE));
    send_item(mk_scan(12'h7FF));
    send_item(mk_report(8'h02, {6{8'd255}}));
    send_item(mk_scan(12'h000));

    // Random phases: receiver-heavy idling, sender-heavy idling, none
    for (int ph = 0; ph < 3; ph++) begin
      set_shift_map(ph != 1);
      tx_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 87 : 0;
      rx_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 33 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (ph == 2 && n == 300) begin
          // long receiver hold while scans keep coming, so the block backs up
          hold_request = 400;
          repeat (30) send_item(mk_scan(rand_lines()));
        end
        send_item(rand_item());
      end
    end

    drain();
    if (board.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/hrkm_pkg.sv
hw/rtl/hrkm_map_store.sv
hw/rtl/hrkm_matrix.sv
hw/rtl/hrkm_seq.sv
hw/rtl/hid_report_to_key_matrix.sv
hw/rtl/hrkm_checker.sv
tb/tb_hid_report_to_key_matrix.sv
